### hw/rtl/fsmf_pkg.sv
// ----------------------------------------------------------------------------
// fsmf_pkg
// shared types and constants of the first substring match finder
// ----------------------------------------------------------------------------
package fsmf_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 6;
    localparam int POS_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PATTERN_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LENGTH    = 3'd4;

    typedef struct packed {
        logic                   wr;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

    typedef struct packed {
        logic take;
        logic clear;
    } t_cell_ctrl;

endpackage

### hw/rtl/fsmf_cell.sv
// ----------------------------------------------------------------------------
// fsmf_cell
// one pattern byte and its prefix match bit, fed by the previous cell's bit
// ----------------------------------------------------------------------------
module fsmf_cell #(
    parameter int BYTE_IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fsmf_pkg::t_cfg_write     i_cfg,
    input  fsmf_pkg::t_cell_ctrl     i_ctrl,
    input  logic [fsmf_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                     i_enable,
    input  logic                     i_prev_bit,
    output logic                     o_bit,
    output logic                     o_next_bit
);
    import fsmf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_IDX =
        CFG_IDX_PATTERN_A + CFG_INDEX_W'(BYTE_IDX / 8);
    localparam int LANE = BYTE_IDX % 8;

    logic [BYTE_W-1:0] r_pat_byte;
    logic              r_bit;
    logic              n_bit;

    assign n_bit      = i_enable & i_prev_bit & (r_pat_byte == i_text_byte);
    assign o_bit      = r_bit;
    assign o_next_bit = n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_byte <= '0;
        end else if (i_cfg.wr && i_cfg.index == REG_IDX) begin
            r_pat_byte <= i_cfg.data[LANE*BYTE_W +: BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.take) begin
            r_bit <= n_bit;
        end
    end

endmodule

### hw/rtl/first_substring_match_finder.sv
// ----------------------------------------------------------------------------
// first_substring_match_finder
// streaming shift-and search for the first occurrence of a configured pattern
// the result is registered and appears in the cycle after the transfer of the last item
// throughput: one text byte per cycle while the input is not stalled, set by the cell row update
// result held in an output register, input stalls while it waits unaccepted
// synchronous active-low reset clears pattern, length and all per-text state
// ----------------------------------------------------------------------------
module first_substring_match_finder #(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int MAX_TEXT_BYTES    = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [fsmf_pkg::BYTE_W-1:0]         i_text_byte,
    input  logic                                i_no_byte,
    input  logic                                i_is_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [fsmf_pkg::POS_W-1:0]          o_match_position,
    output logic                                o_text_overflow,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fsmf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fsmf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fsmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int SUB_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SEL_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);

    t_cfg_write cfg;
    t_cell_ctrl ctrl;

    logic [LEN_W-1:0]             r_len;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_seen;
    logic [POS_W-1:0]             r_start;
    logic                         r_ovf;
    logic                         r_out_valid;
    logic                         r_found;
    logic [POS_W-1:0]             r_pos;
    logic                         r_out_ovf;

    logic [LEN_W-1:0]             len_eff;
    logic [LEN_W-1:0]             len_m1;
    logic [MAX_PATTERN_BYTES-1:0] enable;
    logic [MAX_PATTERN_BYTES-1:0] vec;
    logic [MAX_PATTERN_BYTES-1:0] n_vec;
    logic [MAX_PATTERN_BYTES:0]   prev;
    logic                         accept;
    logic                         has_byte;
    logic                         hit;
    logic [SUB_W-1:0]             start_full;
    logic                         n_seen;
    logic [POS_W-1:0]             n_start;
    logic                         n_ovf;

    assign o_cfg_ready = 1'b1;
    assign cfg.wr      = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign has_byte   = accept && !i_no_byte;
    assign ctrl.take  = has_byte && (r_cnt != CNT_MAX);
    assign ctrl.clear = accept && i_is_last;

    assign len_eff = (r_len > LEN_MAX) ? LEN_MAX : r_len;
    assign len_m1  = len_eff - LEN_W'(1);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            enable[k] = (LEN_W'(k) < len_eff);
        end
    end

    assign prev[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cell
            fsmf_cell #(
                .BYTE_IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cfg       (cfg),
                .i_ctrl      (ctrl),
                .i_text_byte (i_text_byte),
                .i_enable    (enable[g]),
                .i_prev_bit  (prev[g]),
                .o_bit       (vec[g]),
                .o_next_bit  (n_vec[g])
            );
            assign prev[g+1] = vec[g];
        end
    endgenerate

    // match ends on this byte when the top active bit comes up
    assign hit = ctrl.take && (len_eff != '0) && !r_seen && n_vec[len_m1[SEL_W-1:0]];
    assign start_full = SUB_W'(r_cnt) - SUB_W'(len_m1);

    assign n_seen  = r_seen || hit;
    assign n_start = hit ? start_full[POS_W-1:0] : r_start;
    assign n_ovf   = r_ovf || (has_byte && (r_cnt == CNT_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_valid && i_cfg_index == CFG_IDX_LENGTH) begin
            r_len <= i_cfg_data[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
            r_ovf   <= 1'b0;
        end else if (ctrl.clear) begin
            r_cnt   <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_cnt   <= ctrl.take ? r_cnt + CNT_W'(1) : r_cnt;
            r_seen  <= n_seen;
            r_start <= n_start;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.clear) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (ctrl.clear) begin
            if (len_eff == '0) begin
                r_found <= 1'b1;
                r_pos   <= '0;
            end else begin
                r_found <= n_seen;
                r_pos   <= n_seen ? n_start : '0;
            end
            r_out_ovf <= n_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_pos;
    assign o_text_overflow  = r_out_ovf;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first substring match finder: a scoreboard
// class tracks the shift-and search state of each text and checks every
// result, while plain tasks drive texts and pattern writes over the
// valid/ready channels with random idle bursts on both sides
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsmf_pkg::*;

    localparam int MAX_PATTERN = 32;
    localparam int MAX_TEXT    = 65536;

    localparam logic [CFG_INDEX_W-1:0] PATTERN_IDX [4] = '{
        CFG_IDX_PATTERN_A, CFG_IDX_PATTERN_B, CFG_IDX_PATTERN_C, CFG_IDX_PATTERN_D
    };

    typedef logic [BYTE_W-1:0] t_byte_list[$];

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } t_search_result;

    class match_scoreboard;
        logic [CFG_DATA_W-1:0] pattern_word [4];
        logic [LEN_W-1:0]      length_reg;
        logic [31:0]           prefix_vec;
        logic [16:0]           bytes_taken;
        logic                  seen;
        logic [POS_W-1:0]      start_pos;
        logic                  overflowed;
        t_search_result        pending_q[$];
        int                    errors;
        int                    checked;

        function new();
            foreach (pattern_word[i]) pattern_word[i] = '0;
            length_reg = '0;
            errors     = 0;
            checked    = 0;
            clear_text();
        endfunction

        function void clear_text();
            prefix_vec  = '0;
            bytes_taken = '0;
            seen        = 1'b0;
            start_pos   = '0;
            overflowed  = 1'b0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx <= CFG_IDX_PATTERN_D) begin
                pattern_word[idx[1:0]] = data;
            end else if (idx == CFG_IDX_LENGTH) begin
                length_reg = data[LEN_W-1:0];
            end
        endfunction

        function void note_item(logic [BYTE_W-1:0] b, logic nb, logic last);
            int unsigned    len;
            logic [31:0]    hits;
            t_search_result res;
            len = (length_reg > MAX_PATTERN) ? MAX_PATTERN : length_reg;
            if (!nb) begin
                if (bytes_taken >= MAX_TEXT) begin
                    overflowed = 1'b1;
                end else begin
                    hits = '0;
                    for (int k = 0; k < len; k++) begin
                        if (pattern_word[k / 8][(k % 8) * 8 +: 8] == b) hits[k] = 1'b1;
                    end
                    prefix_vec = ((prefix_vec << 1) | 32'd1) & hits;
                    if (len > 0 && !seen && prefix_vec[len - 1]) begin
                        seen      = 1'b1;
                        start_pos = POS_W'(bytes_taken - 17'(len - 1));
                    end
                    bytes_taken++;
                end
            end
            if (last) begin
                res.found    = (len == 0) ? 1'b1 : seen;
                res.position = (len != 0 && seen) ? start_pos : '0;
                res.overflow = overflowed;
                pending_q.push_back(res);
                clear_text();
            end
        endfunction

        task report_mismatch(input string what);
            if (errors < 40) $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(input logic f, input logic [POS_W-1:0] p, input logic o);
            t_search_result want;
            if (pending_q.size() == 0) begin
                report_mismatch("result with no text pending");
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (f !== want.found)
                report_mismatch($sformatf("found got %b want %b", f, want.found));
            if (p !== want.position)
                report_mismatch($sformatf("position got %0d want %0d", p, want.position));
            if (o !== want.overflow)
                report_mismatch($sformatf("overflow got %b want %b", o, want.overflow));
        endtask

        task report_leftovers();
            if (pending_q.size() != 0)
                report_mismatch($sformatf("%0d text results never arrived", pending_q.size()));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [BYTE_W-1:0]      text_byte = '0;
    logic                   no_byte   = 1'b0;
    logic                   is_last   = 1'b0;
    logic                   out_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   res_found;
    logic [POS_W-1:0]       res_position;
    logic                   res_overflow;
    logic                   cfg_ready;

    match_scoreboard sb = new();

    logic [BYTE_W-1:0] pat [MAX_PATTERN];
    int pat_len       = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int hold_cycles   = 0;
    int items_sent    = 0;
    int texts_sent    = 0;
    int settings_used = 0;

    first_substring_match_finder #(
        .MAX_PATTERN_BYTES(MAX_PATTERN),
        .MAX_TEXT_BYTES   (MAX_TEXT)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_text_byte     (text_byte),
        .i_no_byte       (no_byte),
        .i_is_last       (is_last),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_found         (res_found),
        .o_match_position(res_position),
        .o_text_overflow (res_overflow),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // transfers seen at each edge
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
                if (in_valid && in_ready) sb.note_item(text_byte, no_byte, is_last);
                if (out_valid && out_ready) sb.check_result(res_found, res_position, res_overflow);
            end
        end
    end

    // result side
    initial begin
        @(posedge clk);
        forever begin
            if (hold_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    initial begin
        #(64'd100_000_000);
        $display("timeout with %0d results outstanding", sb.pending_q.size());
        $display("status: fail");
        $finish;
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic nb, input logic last);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        no_byte   <= nb;
        is_last   <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input t_byte_list txt, input bit fillers);
        bit nb_end;
        nb_end = (txt.size() == 0) || (fillers && $urandom_range(0, 3) == 0);
        for (int i = 0; i < txt.size(); i++) begin
            if (fillers && $urandom_range(0, 7) == 0) push_byte(BYTE_W'($urandom), 1'b1, 1'b0);
            push_byte(txt[i], 1'b0, !nb_end && i == txt.size() - 1);
        end
        if (nb_end) push_byte(BYTE_W'($urandom), 1'b1, 1'b1);
        texts_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // stray: 0 maybe a random out-of-range write, 1 all-ones to every unused index
    task automatic program_pattern(input logic [CFG_DATA_W-1:0] words [4],
                                   input logic [LEN_W-1:0] len, input int stray);
        int first;
        int idx;
        wait_idle();
        first = $urandom_range(0, 4);
        for (int j = 0; j < 5; j++) begin
            idx = (first + j) % 5;
            if (idx == 4)
                write_reg(CFG_IDX_LENGTH, ({$urandom, $urandom} & ~64'h3F) | CFG_DATA_W'(len));
            else
                write_reg(PATTERN_IDX[idx], words[idx]);
        end
        if (stray == 1) begin
            for (int j = 1; j <= 3; j++) write_reg(CFG_IDX_LENGTH + CFG_INDEX_W'(j), '1);
        end else if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_IDX_LENGTH + CFG_INDEX_W'($urandom_range(1, 3)), {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++) pat[k] = words[k / 8][(k % 8) * 8 +: 8];
        pat_len = (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
        settings_used++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] alpha);
        return ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom)
                                           : alpha + BYTE_W'($urandom_range(0, 3));
    endfunction

    // random text, often carrying the pattern or a broken prefix of it
    function automatic t_byte_list make_text(input logic [BYTE_W-1:0] alpha, input int max_len);
        t_byte_list t;
        int at;
        int cut;
        repeat ($urandom_range(0, max_len)) t.push_back(pick_byte(alpha));
        at = $urandom_range(0, t.size());
        case ($urandom_range(0, 3))
            0, 1: begin
                for (int k = pat_len - 1; k >= 0; k--) t.insert(at, pat[k]);
            end
            2: begin
                if (pat_len > 0) begin
                    cut = $urandom_range(0, pat_len - 1);
                    t.insert(at, pick_byte(alpha));
                    for (int k = cut - 1; k >= 0; k--) t.insert(at, pat[k]);
                end
            end
            default: ;
        endcase
        return t;
    endfunction

    initial begin
        t_byte_list        t;
        logic [63:0]       w [4];
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] alpha;
        int                phase_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern straight from reset
        t = {};
        send_text(t, 1'b0);
        t = {8'h01};
        send_text(t, 1'b0);

        // writes to unused indexes leave the empty pattern alone
        w = '{64'd0, 64'd0, 64'd0, 64'd0};
        program_pattern(w, 6'd0, 1);
        t = {};
        send_text(t, 1'b0);

        // extreme and zero bytes, length masking of the upper bytes
        w = '{{40'($urandom), 24'h0100FF}, 64'('1), 64'd0, {$urandom, $urandom}};
        program_pattern(w, 6'd3, 0);
        t = {8'h01, 8'hFF, 8'h00, 8'h01, 8'hFF};
        send_text(t, 1'b1);
        t = {8'hFF, 8'h00, 8'hFF, 8'h00};
        send_text(t, 1'b0);

        // full length, then a length above the maximum
        w = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}};
        program_pattern(w, 6'd32, 0);
        t = {8'h5A, 8'hA5};
        for (int k = 0; k < MAX_PATTERN; k++) t.push_back(pat[k]);
        send_text(t, 1'b0);
        t = {};
        for (int k = 0; k < MAX_PATTERN - 1; k++) t.push_back(pat[k]);
        send_text(t, 1'b0);
        program_pattern(w, 6'd63, 0);
        t = {};
        for (int k = 0; k < MAX_PATTERN; k++) t.push_back(pat[k]);
        send_text(t, 1'b1);

        // pattern that fills exactly the text
        w = '{{32'($urandom), 32'h83828180}, 64'd0, 64'd0, 64'd0};
        program_pattern(w, 6'd4, 0);
        t = {8'h80, 8'h81, 8'h82, 8'h83};
        send_text(t, 1'b0);

        for (int ph = 0; ph < 16; ph++) begin
            alpha = BYTE_W'($urandom);
            for (int k = 0; k < MAX_PATTERN; k++)
                w[k / 8][(k % 8) * 8 +: 8] = pick_byte(alpha);
            case (ph)
                0: len = 6'd32;
                1: len = 6'd63;
                2: len = 6'd0;
                3: len = 6'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0: len = 6'd0;
                        1: len = LEN_W'($urandom_range(32, 63));
                        2: len = LEN_W'($urandom_range(7, 31));
                        default: len = LEN_W'($urandom_range(1, 6));
                    endcase
                end
            endcase
            if (ph >= 13) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            program_pattern(w, len, 0);
            phase_start = items_sent;
            if (ph == 5) begin
                // results back up while short texts keep coming
                tx_idle_on  = 1'b0;
                hold_cycles = 300;
                repeat (40) send_text(make_text(alpha, 2), 1'b0);
                tx_idle_on  = 1'b1;
            end
            while (items_sent - phase_start < 64) send_text(make_text(alpha, 24), 1'b1);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        sb.report_leftovers();
        $display("covered %0d texts in %0d input transfers over %0d pattern settings, %0d results",
                 texts_sent, items_sent, settings_used, sb.checked);
        $display("included empty patterns and texts, lengths up to 63 and long result stalls");
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/fsmf_pkg.sv
hw/rtl/fsmf_cell.sv
hw/rtl/first_substring_match_finder.sv
tb/tb.sv
